/* hw/rtl/ring_buffer_deque_top_macros.svh */
// Assertion helpers for the deque block.
// Each macro expects clk and arst_n in scope.
`ifndef RING_BUFFER_DEQUE_TOP_MACROS_SVH
`define RING_BUFFER_DEQUE_TOP_MACROS_SVH

// Same-cycle implication.
`define RBD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define RBD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/rbd_pkg.sv */
`default_nettype none
package rbd_pkg;

	// Field widths
	localparam int ACT_W     = 3;
	localparam int INDEX_W   = 8;
	localparam int VALUE_W   = 32;
	localparam int DATA_W    = 32;
	localparam int LEN_W     = 9;
	localparam int STATUS_W  = 2;
	localparam int S_TDATA_W = 40;
	localparam int M_TDATA_W = 48;
	localparam int M_PAD_W   = M_TDATA_W - DATA_W - LEN_W;

	// Request codes
	localparam logic [ACT_W-1:0] ACT_GET      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_PUT      = 3'd1;
	localparam logic [ACT_W-1:0] ACT_REM_HIGH = 3'd2;
	localparam logic [ACT_W-1:0] ACT_REM_LOW  = 3'd3;
	localparam logic [ACT_W-1:0] ACT_ADD_HIGH = 3'd4;
	localparam logic [ACT_W-1:0] ACT_ADD_LOW  = 3'd5;

	// Result status codes
	localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd2;

	// Controller to datapath
	typedef struct packed {
		logic load;    // capture the request and read the store
		logic commit;  // write the store, advance pointers, load the result
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic out_blocked;  // result register full and not being taken
	} sts_t;

endpackage
`default_nettype wire

/* hw/rtl/rbd_ctrl.sv */
`default_nettype none
module rbd_ctrl (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire rbd_pkg::sts_t sts,
	output rbd_pkg::cmd_t     cmd
);
	import rbd_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_EXEC = 2'b10
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.commit = 1'b0;
		s_tready   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				// hold while the previous result still waits
				if (!sts.out_blocked) begin
					cmd.commit = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/rbd_datapath.sv */
`default_nettype none
module rbd_datapath #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire rbd_pkg::cmd_t                  cmd,
	output rbd_pkg::sts_t                       sts,
	input  wire logic [rbd_pkg::S_TDATA_W-1:0]  s_tdata,
	input  wire logic [rbd_pkg::ACT_W-1:0]      s_tuser,
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [rbd_pkg::M_TDATA_W-1:0]       m_tdata,
	output logic [rbd_pkg::STATUS_W-1:0]        m_tuser
);
	import rbd_pkg::*;

	localparam int AW   = $clog2(DEPTH);
	localparam int CW   = $clog2(DEPTH + 1);
	localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;
	localparam int LW   = (CW > LEN_W) ? CW : LEN_W;
	localparam logic [AW:0]   DEPTH_W = (AW+1)'(DEPTH);
	localparam logic [AW-1:0] TOP_POS = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_C  = CW'(DEPTH);

	// Request fields
	logic [ACT_W-1:0]   in_action;
	logic [INDEX_W-1:0] in_index;
	logic [VALUE_W-1:0] in_value;
	logic [63:0]        in_value_ext;

	assign in_action    = s_tuser;
	assign in_index     = s_tdata[INDEX_W-1:0];
	assign in_value     = s_tdata[INDEX_W +: VALUE_W];
	assign in_value_ext = 64'(in_value);

	// Architectural state
	logic [AW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [WIDTH-1:0] mem [DEPTH];

	// Decode
	logic [CMPW-1:0]     idx_c, cnt_c;
	logic [CW-1:0]       cnt_dec;
	logic [AW-1:0]       head_dec, head_inc, off, addr;
	logic [AW:0]         sum, wrapped;
	logic                use_sum, ok;
	logic [STATUS_W-1:0] stat;
	logic [AW-1:0]       nxt_head;
	logic [CW-1:0]       nxt_count;
	logic [AW-1:0]       direct_addr;

	always_comb begin
		idx_c       = CMPW'(in_index);
		cnt_c       = CMPW'(count_q);
		cnt_dec     = count_q - CW'(1);
		head_dec    = (head_q == '0) ? TOP_POS : head_q - AW'(1);
		head_inc    = (head_q == TOP_POS) ? '0 : head_q + AW'(1);
		off         = '0;
		use_sum     = 1'b1;
		direct_addr = head_q;
		ok          = 1'b0;
		stat        = STAT_EMPTY;
		nxt_head    = head_q;
		nxt_count   = count_q;
		case (in_action) inside
			ACT_GET, ACT_PUT: begin
				off  = idx_c[AW-1:0];
				ok   = idx_c < cnt_c;
				stat = ok ? STAT_OK : STAT_EMPTY;
			end
			ACT_REM_HIGH: begin
				off  = cnt_dec[AW-1:0];
				ok   = count_q != '0;
				stat = ok ? STAT_OK : STAT_EMPTY;
				if (ok) nxt_count = cnt_dec;
			end
			ACT_REM_LOW: begin
				use_sum = 1'b0;
				ok      = count_q != '0;
				stat    = ok ? STAT_OK : STAT_EMPTY;
				if (ok) begin
					nxt_head  = head_inc;
					nxt_count = cnt_dec;
				end
			end
			ACT_ADD_HIGH: begin
				off  = count_q[AW-1:0];
				ok   = count_q != FULL_C;
				stat = ok ? STAT_OK : STAT_FULL;
				if (ok) nxt_count = count_q + CW'(1);
			end
			ACT_ADD_LOW: begin
				use_sum     = 1'b0;
				direct_addr = head_dec;
				ok          = count_q != FULL_C;
				stat        = ok ? STAT_OK : STAT_FULL;
				if (ok) begin
					nxt_head  = head_dec;
					nxt_count = count_q + CW'(1);
				end
			end
			default: begin
				ok   = 1'b0;
				stat = STAT_EMPTY;
			end
		endcase
		// logical to physical: one conditional subtract
		sum     = {1'b0, head_q} + {1'b0, off};
		wrapped = (sum >= DEPTH_W) ? sum - DEPTH_W : sum;
		addr    = use_sum ? wrapped[AW-1:0] : direct_addr;
	end

	// Request stage
	logic [ACT_W-1:0]    act_s1;
	logic [AW-1:0]       addr_s1;
	logic                ok_s1;
	logic [STATUS_W-1:0] stat_s1;
	logic [WIDTH-1:0]    value_s1;
	logic [AW-1:0]       nxt_head_s1;
	logic [CW-1:0]       nxt_count_s1;
	logic [WIDTH-1:0]    rd_s1;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_s1       <= in_action;
			addr_s1      <= addr;
			ok_s1        <= ok;
			stat_s1      <= stat;
			value_s1     <= in_value_ext[WIDTH-1:0];
			nxt_head_s1  <= nxt_head;
			nxt_count_s1 <= nxt_count;
		end
	end

	logic wr_en;
	assign wr_en = ok_s1 && (act_s1 == ACT_PUT || act_s1 == ACT_ADD_HIGH
		|| act_s1 == ACT_ADD_LOW);

	// Store: registered read on load, write on commit
	always_ff @(posedge clk) begin
		if (cmd.load) rd_s1 <= mem[addr];
		if (cmd.commit && wr_en) mem[addr_s1] <= value_s1;
	end

	// Result selection
	logic [63:0]        rd_ext, val_ext;
	logic [DATA_W-1:0]  res_data;
	logic [LW-1:0]      len_ext;
	logic               is_add;

	assign rd_ext  = 64'(rd_s1);
	assign val_ext = 64'(value_s1);
	assign is_add  = act_s1 == ACT_ADD_HIGH || act_s1 == ACT_ADD_LOW;
	assign len_ext = LW'(nxt_count_s1);

	always_comb begin
		if (!ok_s1) begin
			res_data = '0;
		end else if (is_add) begin
			res_data = val_ext[DATA_W-1:0];
		end else begin
			res_data = rd_ext[DATA_W-1:0];
		end
	end

	// Pointers and output register
	logic                out_valid_q;
	logic [DATA_W-1:0]   out_data_q;
	logic [LEN_W-1:0]    out_len_q;
	logic [STATUS_W-1:0] out_stat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.commit) begin
				head_q      <= nxt_head_s1;
				count_q     <= nxt_count_s1;
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_data_q <= res_data;
			out_len_q  <= len_ext[LEN_W-1:0];
			out_stat_q <= stat_s1;
		end
	end

	assign sts.out_blocked = out_valid_q && !m_tready;
	assign m_tvalid        = out_valid_q;
	assign m_tdata         = {{M_PAD_W{1'b0}}, out_len_q, out_data_q};
	assign m_tuser         = out_stat_q;

endmodule
`default_nettype wire

/* hw/rtl/ring_buffer_deque_top.sv */
`default_nettype none
// Double-ended queue of up to DEPTH elements of WIDTH bits in a circular store.
// Each request beat on the s_ side gives exactly one result beat on the m_ side, in
// order. A request is accepted, then committed: in the accept cycle the logical index
// is mapped to a physical slot and the single-port store is read into a register; at
// commit, which waits while the previous result is not yet taken, the store is written
// (put, add), the head pointer and count are advanced and the result is loaded into the
// output register. No new request is accepted until the current one is committed. The
// output register lets the next request be accepted while a result still waits; if
// that result is still not taken when the next one is ready, the block holds until it
// is. The store has no reset and needs no clearing pass: it is read for every request,
// but data from a slot that holds no element is never returned. Refused requests
// (remove when empty, index of length or more, unknown code) return data 0 with status
// empty; an add when full returns data 0 with status full; state is left unchanged in
// both cases. The length field reports the element count after the request.
module ring_buffer_deque_top #(
	parameter int DEPTH = 256,
	parameter int WIDTH = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	output logic                               s_tready,
	// s_tdata: [7:0] index, [39:8] value
	input  wire logic [rbd_pkg::S_TDATA_W-1:0] s_tdata,
	// s_tuser: [2:0] action
	input  wire logic [rbd_pkg::ACT_W-1:0]     s_tuser,
	output logic                               m_tvalid,
	input  wire logic                          m_tready,
	// m_tdata: [31:0] data, [40:32] length, [47:41] zero
	output logic [rbd_pkg::M_TDATA_W-1:0]      m_tdata,
	// m_tuser: [1:0] status
	output logic [rbd_pkg::STATUS_W-1:0]       m_tuser
);
	import rbd_pkg::*;

	`include "ring_buffer_deque_top_macros.svh"

	cmd_t cmd;
	sts_t sts;

	// Sequencing: accept, then commit
	rbd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Store, pointers and result register
	rbd_datapath #(
		.DEPTH (DEPTH),
		.WIDTH (WIDTH)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// Result beat views for the checks below
	logic             full_beat;
	logic [LEN_W-1:0] res_len;

	assign full_beat = m_tvalid && m_tuser == STAT_FULL;
	assign res_len   = m_tdata[DATA_W +: LEN_W];

	// One request in flight: after an accepted beat, ready is low in the next cycle
	`RBD_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready, "request overlap")
	// A commit always leaves a result for the master side
	`RBD_ASSERT_NEXT(a_commit_gives_result, cmd.commit, m_tvalid, "commit lost result")
	// A refused add reports the store as full: its length equals DEPTH
	`RBD_ASSERT_NOW(a_full_len, full_beat, res_len == LEN_W'(DEPTH), "full with short length")

endmodule
`default_nettype wire

/* verif/ring_buffer_deque_top_test.sv */
`default_nettype none
module ring_buffer_deque_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rbd_pkg::*;

	localparam int          DEPTH       = 256;
	localparam int          WIDTH       = 32;
	localparam int          RANDOM_REQS = 525;
	localparam int unsigned CYCLE_LIMIT = 200000;

	// Request codes the block must refuse; the package names only the six real ones.
	localparam logic [ACT_W-1:0] ACT_SPARE_A = 3'd6;
	localparam logic [ACT_W-1:0] ACT_SPARE_B = 3'd7;

	// One request beat, plus the sender's idle gap before it and a flag that
	// makes the sender wait for every outstanding result first.
	typedef struct {
		logic [ACT_W-1:0]   action;
		logic [INDEX_W-1:0] index;
		logic [VALUE_W-1:0] value;
		int unsigned        gap;
		bit                 drain;
	} request_t;

	// One result beat as the deque should report it.
	typedef struct {
		logic [DATA_W-1:0]   data;
		logic [LEN_W-1:0]    length;
		logic [STATUS_W-1:0] status;
	} outcome_t;

	// Shapes of the random traffic: grow to full, sit on full, shrink to empty,
	// sit on empty, then churn around the middle before growing again.
	typedef enum logic [2:0] {
		MODE_FILLING,
		MODE_AT_FULL,
		MODE_DRAINING,
		MODE_AT_EMPTY,
		MODE_CHURN
	} traffic_mode_t;

	logic                  clk      = 1'b0;
	logic                  arst_n   = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata  = '0;
	logic [ACT_W-1:0]      s_tuser  = '0;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [STATUS_W-1:0]   m_tuser;

	ring_buffer_deque_top #(
		.DEPTH(DEPTH),
		.WIDTH(WIDTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),   // [7:0] index, [39:8] value
		.s_tuser  (s_tuser),   // [2:0] action
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),   // [31:0] data, [40:32] length, [47:41] zero
		.m_tuser  (m_tuser)    // [1:0] status
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Requests waiting to be driven, and results owed by the block, oldest first.
	request_t    pending_reqs[$];
	outcome_t    owed_results[$];

	// Shadow of the deque: circular store, head slot and element count.
	logic [DATA_W-1:0]  shadow_mem [DEPTH];
	logic [INDEX_W-1:0] shadow_head = '0;
	logic [LEN_W-1:0]   shadow_count = '0;

	// Generator bookkeeping: element count as the stimulus will leave it.
	int unsigned   gen_count = 0;
	traffic_mode_t gen_mode  = MODE_FILLING;
	int unsigned   hold_left = 0;
	int unsigned   tx_calm   = 0;
	int unsigned   rx_calm   = 0;

	// Run statistics and failures.
	int unsigned errors       = 0;
	int unsigned reqs_sent    = 0;
	int unsigned results_seen = 0;
	int unsigned full_refused = 0;
	int unsigned empty_refused = 0;
	int unsigned peak_length  = 0;

	// Apply one request to the shadow deque and return the result it owes.
	// Logical index i lives in slot head + i; the 8-bit slot wraps round the ring.
	function automatic outcome_t deque_apply(request_t req);
		outcome_t           res;
		logic [INDEX_W-1:0] slot;
		res.data   = '0;
		res.status = STAT_OK;
		case (req.action) inside
			ACT_GET, ACT_PUT: begin
				if (LEN_W'(req.index) >= shadow_count) begin
					res.status = STAT_EMPTY;
				end else begin
					slot     = shadow_head + req.index;
					res.data = shadow_mem[slot];
					if (req.action == ACT_PUT)
						shadow_mem[slot] = req.value;
				end
			end
			ACT_REM_HIGH: begin
				if (shadow_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					shadow_count = shadow_count - LEN_W'(1);
					slot         = shadow_head + shadow_count[INDEX_W-1:0];
					res.data     = shadow_mem[slot];
				end
			end
			ACT_REM_LOW: begin
				if (shadow_count == 0) begin
					res.status = STAT_EMPTY;
				end else begin
					res.data     = shadow_mem[shadow_head];
					shadow_head  = shadow_head + INDEX_W'(1);
					shadow_count = shadow_count - LEN_W'(1);
				end
			end
			ACT_ADD_HIGH: begin
				if (shadow_count >= DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					slot             = shadow_head + shadow_count[INDEX_W-1:0];
					shadow_mem[slot] = req.value;
					shadow_count     = shadow_count + LEN_W'(1);
					res.data         = req.value;
				end
			end
			ACT_ADD_LOW: begin
				if (shadow_count >= DEPTH) begin
					res.status = STAT_FULL;
				end else begin
					shadow_head             = shadow_head - INDEX_W'(1);
					shadow_mem[shadow_head] = req.value;
					shadow_count            = shadow_count + LEN_W'(1);
					res.data                = req.value;
				end
			end
			default: res.status = STAT_EMPTY;
		endcase
		res.length = shadow_count;
		return res;
	endfunction

	// Idle gap before the next beat: usually random, with calm stretches of none.
	function automatic int unsigned draw_wait(inout int unsigned calm);
		if (calm != 0) begin
			calm = calm - 1;
			return 0;
		end
		if ($urandom_range(0, 24) == 0) begin
			calm = $urandom_range(15, 50);
			return 0;
		end
		return $urandom_range(0, 17);
	endfunction

	// Append a request and track the element count it will leave behind.
	function automatic void queue_request(logic [ACT_W-1:0] act, logic [INDEX_W-1:0] idx,
			logic [VALUE_W-1:0] val, bit drain);
		request_t req;
		req.action = act;
		req.index  = idx;
		req.value  = val;
		req.gap    = draw_wait(tx_calm);
		req.drain  = drain;
		pending_reqs.push_back(req);
		if ((act == ACT_ADD_HIGH || act == ACT_ADD_LOW) && gen_count < DEPTH)
			gen_count++;
		else if ((act == ACT_REM_HIGH || act == ACT_REM_LOW) && gen_count != 0)
			gen_count--;
	endfunction

	// Driver: present one request at a time, honour its idle gap and any drain
	// hold, and predict its result at the edge where the beat is taken.
	request_t cur_req;
	bit       staged    = 1'b0;
	int       idle_left = 0;

	always @(posedge clk or negedge arst_n) begin : request_driver
		outcome_t outcome;
		if (!arst_n) begin
			s_tvalid  <= 1'b0;
			s_tdata   <= '0;
			s_tuser   <= '0;
			staged    = 1'b0;
			idle_left = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				outcome = deque_apply(cur_req);
				owed_results.push_back(outcome);
				reqs_sent++;
				if (outcome.status == STAT_FULL)
					full_refused++;
				else if (outcome.status == STAT_EMPTY)
					empty_refused++;
				if (32'(outcome.length) > peak_length)
					peak_length = 32'(outcome.length);
			end
			// Slot is free: stage the next request, then either raise valid or idle.
			if ((s_tvalid && s_tready) || !s_tvalid) begin
				if (!staged && pending_reqs.size() != 0) begin
					cur_req   = pending_reqs.pop_front();
					idle_left = cur_req.gap;
					staged    = 1'b1;
				end
				if (staged && idle_left == 0 && !(cur_req.drain && owed_results.size() != 0))
						begin
					s_tvalid <= 1'b1;
					s_tdata  <= {cur_req.value, cur_req.index};
					s_tuser  <= cur_req.action;
					staged   = 1'b0;
				end else begin
					s_tvalid <= 1'b0;
					if (staged && idle_left > 0)
						idle_left--;
				end
			end
		end
	end

	// Monitor: check every result beat against the oldest owed result, then
	// drop ready for a random stall, possibly none, after it.
	int unsigned ready_hold = 0;

	always @(posedge clk or negedge arst_n) begin : result_monitor
		outcome_t want;
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_hold = 0;
		end else if (m_tvalid && m_tready) begin
			results_seen++;
			if (owed_results.size() == 0) begin
				$error("result beat with nothing owed: data %h, length %0d, status %0d",
					m_tdata[DATA_W-1:0], m_tdata[DATA_W +: LEN_W], m_tuser);
				errors++;
			end else begin
				want = owed_results.pop_front();
				if (m_tdata[DATA_W-1:0] !== want.data) begin
					$error("data: expected %h, got %h", want.data, m_tdata[DATA_W-1:0]);
					errors++;
				end
				if (m_tdata[DATA_W +: LEN_W] !== want.length) begin
					$error("length: expected %0d, got %0d", want.length,
						m_tdata[DATA_W +: LEN_W]);
					errors++;
				end
				if (m_tuser !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, m_tuser);
					errors++;
				end
				if (m_tdata[M_TDATA_W-1 -: M_PAD_W] !== '0) begin
					$error("pad: expected %h, got %h", {M_PAD_W{1'b0}},
						m_tdata[M_TDATA_W-1 -: M_PAD_W]);
					errors++;
				end
			end
			ready_hold = draw_wait(rx_calm);
			if (ready_hold != 0)
				m_tready <= 1'b0;
		end else if (!m_tready) begin
			if (ready_hold <= 1) begin
				m_tready   <= 1'b1;
				ready_hold = 0;
			end else begin
				ready_hold--;
			end
		end
	end

	// Watchdog: give up well beyond the slowest legal run.
	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	initial begin : stimulus
		int unsigned        roll;
		int unsigned        add_pct;
		int unsigned        rem_pct;
		logic [ACT_W-1:0]   act;
		logic [INDEX_W-1:0] idx;

		// Directed: refusals on an empty deque, unknown codes, head wrap below
		// slot 0, reads at both ends and past the end, overwrites, removal from
		// both ends down to empty again.
		queue_request(ACT_GET,      8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_PUT,      8'd0,   32'h1234_5678, 1'b0);
		queue_request(ACT_REM_HIGH, 8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_REM_LOW,  8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_SPARE_A,  8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_SPARE_B,  8'hff,  32'hffff_ffff, 1'b0);
		queue_request(ACT_ADD_LOW,  8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_ADD_HIGH, 8'hff,  32'hffff_ffff, 1'b0);
		queue_request(ACT_ADD_LOW,  8'd0,   32'ha5a5_a5a5, 1'b0);
		queue_request(ACT_ADD_HIGH, 8'd0,   32'h5a5a_5a5a, 1'b0);
		queue_request(ACT_GET,      8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_GET,      8'd3,   32'hffff_ffff, 1'b0);
		queue_request(ACT_GET,      8'd4,   32'h0000_0000, 1'b0);
		queue_request(ACT_GET,      8'hff,  32'h0000_0000, 1'b0);
		queue_request(ACT_PUT,      8'd3,   32'h8000_0001, 1'b0);
		queue_request(ACT_PUT,      8'd0,   32'hffff_ffff, 1'b0);
		queue_request(ACT_PUT,      8'd4,   32'hdead_beef, 1'b0);
		queue_request(ACT_GET,      8'd3,   32'h0000_0000, 1'b0);
		queue_request(ACT_REM_LOW,  8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_REM_HIGH, 8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_REM_HIGH, 8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_REM_LOW,  8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_REM_LOW,  8'd0,   32'h0000_0000, 1'b0);
		queue_request(ACT_ADD_HIGH, 8'd0,   32'h0000_0001, 1'b0);
		queue_request(ACT_REM_HIGH, 8'd0,   32'h0000_0000, 1'b0);

		// Random: biased phases so the deque fills to capacity, sits on full,
		// drains to empty and churns; indexes mostly land inside the held range.
		for (int n = 0; n < RANDOM_REQS; n++) begin
			case (gen_mode)
				MODE_FILLING:  begin add_pct = 84; rem_pct = 4;  end
				MODE_AT_FULL:  begin add_pct = 70; rem_pct = 5;  end
				MODE_DRAINING: begin add_pct = 4;  rem_pct = 84; end
				MODE_AT_EMPTY: begin add_pct = 5;  rem_pct = 60; end
				default:       begin add_pct = 35; rem_pct = 35; end
			endcase
			roll = $urandom_range(0, 99);
			if (roll < add_pct)
				act = $urandom_range(0, 1) ? ACT_ADD_HIGH : ACT_ADD_LOW;
			else if (roll < add_pct + rem_pct)
				act = $urandom_range(0, 1) ? ACT_REM_HIGH : ACT_REM_LOW;
			else if ($urandom_range(0, 14) == 0)
				act = $urandom_range(0, 1) ? ACT_SPARE_A : ACT_SPARE_B;
			else
				act = $urandom_range(0, 1) ? ACT_PUT : ACT_GET;
			if (gen_count != 0 && $urandom_range(0, 4) != 0)
				idx = INDEX_W'($urandom_range(0, gen_count - 1));
			else
				idx = INDEX_W'($urandom_range(0, 255));
			// Hold the sender until the pipeline is empty on the first random
			// request and now and then after.
			queue_request(act, idx, $urandom(), n == 0 || $urandom_range(0, 99) == 0);

			case (gen_mode)
				MODE_FILLING: begin
					if (gen_count == DEPTH) begin
						gen_mode  = MODE_AT_FULL;
						hold_left = 8;
					end
				end
				MODE_AT_FULL: begin
					hold_left--;
					if (hold_left == 0)
						gen_mode = MODE_DRAINING;
				end
				MODE_DRAINING: begin
					if (gen_count == 0) begin
						gen_mode  = MODE_AT_EMPTY;
						hold_left = 6;
					end
				end
				MODE_AT_EMPTY: begin
					hold_left--;
					if (hold_left == 0) begin
						gen_mode  = MODE_CHURN;
						hold_left = 60;
					end
				end
				default: begin
					hold_left--;
					if (hold_left == 0)
						gen_mode = MODE_FILLING;
				end
			endcase
		end

		// Reset once, then let the driver and monitor run the queue dry.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(posedge clk);
		while (pending_reqs.size() != 0 || staged || s_tvalid || owed_results.size() != 0);

		// Allow a stray late beat to show up before judging.
		repeat (16) @(posedge clk);
		if (owed_results.size() != 0) begin
			$error("%0d results never arrived", owed_results.size());
			errors++;
		end

		$display("deque run: %0d requests, %0d results checked, peak length %0d",
			reqs_sent, results_seen, peak_length);
		$display("refusals: %0d on full, %0d on empty, out of range or unknown code",
			full_refused, empty_refused);
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
`default_nettype wire
